// ===== rtl/amc_pkg.sv =====
// ----------------------------------------------------------------------------
// Aperture mask classifier package
// Shared codes and fixed field widths for the classifier and its checker.
// ----------------------------------------------------------------------------
package amc_pkg;

   // Fixed widths of fields that do not follow the coordinate width.
   localparam int CSR_IDX_W = 2;
   localparam int COUNT_W   = 7;
   localparam int ENTRY_W   = 6;
   localparam int SHAPE_W   = 2;
   localparam int HIT_W     = 2;

   // Control register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OUTER_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE_MODE   = 2'd2;

   // Plate radius after reset: 200 cm at 1/256 cm per LSB.
   localparam int RADIUS_RESET = 51200;

   // Shape modes applied when an entry is loaded.
   localparam logic [SHAPE_W-1:0] SHAPE_AUTO   = 2'd0;
   localparam logic [SHAPE_W-1:0] SHAPE_CIRCLE = 2'd1;
   localparam logic [SHAPE_W-1:0] SHAPE_RECT   = 2'd2;

   // Request modes.
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_POINT = 1'b1;

   // Hit classes returned for a point.
   localparam logic [HIT_W-1:0] HIT_OUTSIDE = 2'd0;
   localparam logic [HIT_W-1:0] HIT_WINDOW  = 2'd1;
   localparam logic [HIT_W-1:0] HIT_FRAME   = 2'd2;

endpackage

// ===== rtl/aperture_mask_classifier.sv =====
// ----------------------------------------------------------------------------
// Aperture mask classifier
// Holds a table of circular and rectangular windows on a round plate and
// classifies impact points as outside the plate, through a window, or on
// the frame.
//
//   Channel  Direction  Handshake              Payload
//   req_     in         req_valid/req_ready    mode, entry, center, size, point
//   rsp_     out        rsp_valid/rsp_ready    hit_class
//   csr_     in         csr_valid/csr_ready    index, wdata
//
// A load transfer writes the table in its accept cycle.
// A point is tested against the plate, then against each rectangle or circle
// in table order; the scan stops at the first window passed.
// One shared squarer does every product, one per cycle.
// Reset is synchronous; the table itself is not cleared by reset.
// A stalled response holds the block in its final state until taken.
// ----------------------------------------------------------------------------
module aperture_mask_classifier
   import amc_pkg::*;
#(
   parameter int MAX_WINDOWS = 64,
   parameter int COORD_BITS  = 24
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_mode,
   input  logic [ENTRY_W-1:0]            req_entry_index,
   input  logic signed [COORD_BITS-1:0]  req_center_y,
   input  logic signed [COORD_BITS-1:0]  req_center_z,
   input  logic [COORD_BITS-2:0]         req_size_width,
   input  logic [COORD_BITS-2:0]         req_size_height,
   input  logic signed [COORD_BITS-1:0]  req_point_y,
   input  logic signed [COORD_BITS-1:0]  req_point_z,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [HIT_W-1:0]              rsp_hit_class,

   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [COORD_BITS-2:0]         csr_wdata
);

   localparam int CW    = COORD_BITS;
   localparam int SW    = COORD_BITS - 1;
   localparam int MW    = COORD_BITS + 1;
   localparam int PW    = 2 * MW;
   localparam int IDX_W = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
   localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

   typedef struct packed {
      logic [CW-1:0] cy;
      logic [CW-1:0] cz;
      logic [SW-1:0] size_a;
      logic [SW-1:0] size_b;
      logic          is_rect;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQ_Y,
      S_SQ_Z,
      S_SQ_R,
      S_CMP,
      S_READ,
      S_DIFF,
      S_RECT,
      S_DONE
   } state_type;

   // Magnitude of a sign-extended difference.
   function automatic logic [MW-1:0] mag_of(input logic [MW-1:0] d);
      logic [MW-1:0] neg;
      neg = ~d + 1'b1;
      return d[MW-1] ? neg : d;
   endfunction

   state_type             state_ff;
   logic                  is_plate_ff;
   logic [CW-1:0]         py_ff;
   logic [CW-1:0]         pz_ff;
   logic [MW-1:0]         mag_y_ff;
   logic [MW-1:0]         mag_z_ff;
   logic [SW-1:0]         rad_ff;
   logic [PW-1:0]         sq_ff;
   logic [PW-1:0]         acc_ff;
   logic [CNT_W-1:0]      idx_ff;
   logic [CNT_W-1:0]      n_ff;
   logic [HIT_W-1:0]      result_ff;
   logic                  rsp_valid_ff;
   logic [HIT_W-1:0]      rsp_hit_class_ff;

   logic [SW-1:0]         outer_radius_ff;
   logic [COUNT_W-1:0]    window_count_ff;
   logic [SHAPE_W-1:0]    shape_mode_ff;

   entry_type             table_mem [MAX_WINDOWS];
   entry_type             rd_ff;
   entry_type             wr_entry;

   logic                  req_xfer;
   logic                  load_xfer;
   logic                  load_rect;
   logic [MW-1:0]         sq_op;
   logic [PW-1:0]         sq_in;
   logic                  circle_pass;
   logic                  rect_pass;
   logic [CNT_W-1:0]      next_idx;
   logic [CNT_W-1:0]      count_sat;
   logic [MW-1:0]         dy;
   logic [MW-1:0]         dz;
   logic                  out_free;
   logic                  rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit_class = rsp_hit_class_ff;

   assign req_xfer  = req_valid && req_ready;
   assign load_xfer = req_xfer && (req_mode == MODE_LOAD);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // The response register fills when a point finishes and empties on a transfer.
   assign rsp_valid_in = ((state_ff == S_DONE) && out_free) || (rsp_valid_ff && !rsp_ready);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         outer_radius_ff <= SW'(RADIUS_RESET);
         window_count_ff <= '0;
         shape_mode_ff   <= SHAPE_AUTO;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OUTER_RADIUS: outer_radius_ff <= csr_wdata;
            CSR_WINDOW_COUNT: window_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_SHAPE_MODE:   shape_mode_ff   <= csr_wdata[SHAPE_W-1:0];
            default: ;
         endcase
      end
   end

   // Shape decision for a load; the unused mode code behaves as auto.
   always_comb begin
      unique case (shape_mode_ff)
         SHAPE_CIRCLE: load_rect = 1'b0;
         SHAPE_RECT:   load_rect = 1'b1;
         default:      load_rect = (req_size_height != '0);
      endcase
   end

   assign wr_entry.cy      = req_center_y;
   assign wr_entry.cz      = req_center_z;
   assign wr_entry.size_a  = req_size_width;
   assign wr_entry.size_b  = load_rect ? req_size_height : '0;
   assign wr_entry.is_rect = load_rect;

   // Window table: one write port for loads, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (load_xfer && (req_entry_index < MAX_WINDOWS)) begin
         table_mem[IDX_W'(req_entry_index)] <= wr_entry;
      end
      rd_ff <= table_mem[idx_ff[IDX_W-1:0]];
   end

   // Shared squarer operand selection.
   always_comb begin
      unique case (state_ff)
         S_SQ_Y:  sq_op = mag_y_ff;
         S_SQ_Z:  sq_op = mag_z_ff;
         default: sq_op = MW'(rad_ff);
      endcase
   end

   assign sq_in = sq_op * sq_op;

   // Window offsets and tests.
   assign dy = {py_ff[CW-1], py_ff} - {rd_ff.cy[CW-1], rd_ff.cy};
   assign dz = {pz_ff[CW-1], pz_ff} - {rd_ff.cz[CW-1], rd_ff.cz};
   assign circle_pass = (acc_ff <= sq_ff);
   assign rect_pass = ({mag_y_ff, 1'b0} < (MW + 1)'(rd_ff.size_a)) &&
                      ({mag_z_ff, 1'b0} < (MW + 1)'(rd_ff.size_b));
   assign next_idx = idx_ff + 1'b1;
   assign count_sat = (window_count_ff > MAX_WINDOWS) ? CNT_W'(MAX_WINDOWS)
                                                      : CNT_W'(window_count_ff);

   // Sequencer with the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            S_IDLE: begin
               if (req_xfer && (req_mode == MODE_POINT)) begin
                  py_ff       <= req_point_y;
                  pz_ff       <= req_point_z;
                  mag_y_ff    <= mag_of({req_point_y[CW-1], req_point_y});
                  mag_z_ff    <= mag_of({req_point_z[CW-1], req_point_z});
                  rad_ff      <= outer_radius_ff;
                  is_plate_ff <= 1'b1;
                  n_ff        <= count_sat;
                  idx_ff      <= '0;
                  state_ff    <= S_SQ_Y;
               end
            end
            S_SQ_Y: begin
               sq_ff    <= sq_in;
               state_ff <= S_SQ_Z;
            end
            S_SQ_Z: begin
               sq_ff    <= sq_in;
               acc_ff   <= sq_ff;
               state_ff <= S_SQ_R;
            end
            S_SQ_R: begin
               sq_ff    <= sq_in;
               acc_ff   <= acc_ff + sq_ff;
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (is_plate_ff) begin
                  if (!circle_pass) begin
                     result_ff <= HIT_OUTSIDE;
                     state_ff  <= S_DONE;
                  end else if (n_ff == '0) begin
                     result_ff <= HIT_FRAME;
                     state_ff  <= S_DONE;
                  end else begin
                     state_ff <= S_READ;
                  end
               end else if (circle_pass) begin
                  result_ff <= HIT_WINDOW;
                  state_ff  <= S_DONE;
               end else if (next_idx == n_ff) begin
                  result_ff <= HIT_FRAME;
                  state_ff  <= S_DONE;
               end else begin
                  idx_ff   <= next_idx;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_DIFF;
            end
            S_DIFF: begin
               mag_y_ff    <= mag_of(dy);
               mag_z_ff    <= mag_of(dz);
               rad_ff      <= rd_ff.size_a;
               is_plate_ff <= 1'b0;
               state_ff    <= rd_ff.is_rect ? S_RECT : S_SQ_Y;
            end
            S_RECT: begin
               if (rect_pass) begin
                  result_ff <= HIT_WINDOW;
                  state_ff  <= S_DONE;
               end else if (next_idx == n_ff) begin
                  result_ff <= HIT_FRAME;
                  state_ff  <= S_DONE;
               end else begin
                  idx_ff   <= next_idx;
                  state_ff <= S_READ;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_hit_class_ff <= result_ff;
                  state_ff         <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/amc_checker.sv =====
// ----------------------------------------------------------------------------
// Aperture mask classifier checker
// Port-level checks on the classifier, attached to it by a bind.
// ----------------------------------------------------------------------------
module amc_checker
   import amc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             req_mode,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [HIT_W-1:0] rsp_hit_class
);

   // A response that is not taken holds its class.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit_class))
      else $error("stalled response changed");

   // Only the three defined classes are returned.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit_class == HIT_OUTSIDE || rsp_hit_class == HIT_WINDOW ||
                     rsp_hit_class == HIT_FRAME))
      else $error("undefined hit class");

   // A point transfer occupies the block for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_mode == MODE_POINT) |=> !req_ready)
      else $error("ready after point transfer");

   // No response is pending right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind aperture_mask_classifier amc_checker u_amc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_mode      (req_mode),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_hit_class (rsp_hit_class)
);
